/* rtl/bezier_patch_evaluator_unit_macros.svh */
// Assertion helpers shared by the checker
`ifndef BEZIER_PATCH_EVALUATOR_UNIT_MACROS_SVH
`define BEZIER_PATCH_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication, off during reset
`define BPE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bezier patch evaluator check failed");

// Next-cycle implication, off during reset
`define BPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bezier patch evaluator check failed");

`endif

/* rtl/bpe_pkg.sv */
package bpe_pkg;

   localparam int MAX_DIM = 16;
   localparam int DIM_W   = $clog2(MAX_DIM) + 1;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int COORD_W = 32;
   localparam int POINT_W = 3 * COORD_W;
   localparam int T_W     = 17;

   localparam logic [T_W-1:0]   ONE_Q16  = 17'h10000;
   localparam logic [DIM_W-1:0] DIM_MAX  = DIM_W'(MAX_DIM);
   localparam logic             CMD_WRITE = 1'b0;
   localparam logic             CMD_EVAL  = 1'b1;
   localparam logic             REG_COLUMNS = 1'b0;
   localparam logic             REG_ROWS    = 1'b1;

   typedef logic [POINT_W-1:0] point_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              ram_we;
      logic              ram_re;
      logic [ADDR_W-1:0] ram_addr;
      logic              load_param;
      logic              wq_pop_hold;
      logic              wq_lerp;
      logic              move;
      logic              cq_pop_hold;
      logic              cq_lerp;
      logic              out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // Clamp a grid size to 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) r = DIM_W'(1);
      else if (d > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

   // a + round((b - a) * t / 65536), halves up, saturated to 32 bits
   function automatic logic [COORD_W-1:0] lerp_q16(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b,
                                                   input logic [T_W-1:0] t);
      logic signed [COORD_W:0]     diff;
      logic signed [COORD_W+T_W+1:0] prod;
      logic signed [COORD_W+T_W+2:0] sum;
      logic [COORD_W-1:0]          r;
      diff = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
      prod = diff * $signed({1'b0, t});
      prod = prod + 32768;
      sum  = (prod >>> 16) + $signed(a);
      if (sum > $signed({{(T_W+3){1'b0}}, 1'b0, {(COORD_W-1){1'b1}}}))
         r = {1'b0, {(COORD_W-1){1'b1}}};
      else if (sum < $signed({{(T_W+3){1'b1}}, 1'b1, {(COORD_W-1){1'b0}}}))
         r = {1'b1, {(COORD_W-1){1'b0}}};
      else
         r = sum[COORD_W-1:0];
      return r;
   endfunction

endpackage

/* rtl/bpe_ram.sv */
module bpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/bpe_queue.sv */
// Shift queue: read at the head, write behind the last live entry
module bpe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop,
   input  logic               push,
   input  bpe_pkg::point_type push_data,
   output bpe_pkg::point_type head
);

   bpe_pkg::point_type            slot_ff [bpe_pkg::MAX_DIM];
   bpe_pkg::point_type            slot_in [bpe_pkg::MAX_DIM];
   logic [bpe_pkg::DIM_W-1:0]     count_ff, count_in, wpos;

   always_comb begin
      wpos = count_ff - bpe_pkg::DIM_W'(pop);
      for (int i = 0; i < bpe_pkg::MAX_DIM; i++) begin
         slot_in[i] = slot_ff[i];
      end
      // Advance every entry one place toward the head
      if (pop) begin
         for (int i = 0; i < bpe_pkg::MAX_DIM - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
      if (push) slot_in[wpos[bpe_pkg::IDX_W-1:0]] = push_data;
      count_in = wpos + bpe_pkg::DIM_W'(push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < bpe_pkg::MAX_DIM; i++) slot_ff[i] <= slot_in[i];
   end

   assign head = slot_ff[0];

endmodule

/* rtl/bpe_datapath.sv */
module bpe_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  bpe_pkg::ctl_cmd_type        cmd,
   output bpe_pkg::dp_status_type      status,
   input  bpe_pkg::point_type          wr_point,
   input  logic [bpe_pkg::T_W-1:0]     u_in,
   input  logic [bpe_pkg::T_W-1:0]     v_in,
   output logic                        out_valid,
   input  logic                        out_ready,
   output bpe_pkg::point_type          out_point
);

   bpe_pkg::point_type        ram_rdata, wq_head, cq_head, lerp_res, wq_push_data;
   bpe_pkg::point_type        a_op, b_op, cq_push_data;
   bpe_pkg::point_type        whold_ff, chold_ff, out_ff;
   logic [bpe_pkg::T_W-1:0]   u_ff, v_ff, t_sel;
   logic                      rd_pend_ff, out_valid_ff;
   logic                      wq_cmd;

   bpe_ram #(.WIDTH(bpe_pkg::POINT_W), .DEPTH(bpe_pkg::DEPTH)) u_ram (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (cmd.ram_addr),
      .wdata (wr_point),
      .re    (cmd.ram_re),
      .raddr (cmd.ram_addr),
      .rdata (ram_rdata)
   );

   // Shared interpolator: row pass uses v, column pass uses u
   always_comb begin
      wq_cmd = cmd.wq_lerp;
      a_op   = wq_cmd ? whold_ff : chold_ff;
      b_op   = wq_cmd ? wq_head : cq_head;
      t_sel  = wq_cmd ? v_ff : u_ff;
      for (int j = 0; j < 3; j++) begin
         lerp_res[j*bpe_pkg::COORD_W +: bpe_pkg::COORD_W] = bpe_pkg::lerp_q16(
            a_op[j*bpe_pkg::COORD_W +: bpe_pkg::COORD_W],
            b_op[j*bpe_pkg::COORD_W +: bpe_pkg::COORD_W], t_sel);
      end
      wq_push_data = rd_pend_ff ? ram_rdata : lerp_res;
      cq_push_data = cmd.move ? wq_head : lerp_res;
   end

   bpe_queue u_wq (
      .clock     (clock),
      .reset     (reset),
      .pop       (cmd.wq_pop_hold | cmd.wq_lerp | cmd.move),
      .push      (rd_pend_ff | cmd.wq_lerp),
      .push_data (wq_push_data),
      .head      (wq_head)
   );

   bpe_queue u_cq (
      .clock     (clock),
      .reset     (reset),
      .pop       (cmd.cq_pop_hold | cmd.cq_lerp | cmd.out_load),
      .push      (cmd.move | cmd.cq_lerp),
      .push_data (cq_push_data),
      .head      (cq_head)
   );

   // Hold the left operand, the parameters and the result
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.ram_re;
         if (cmd.out_load) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
      if (cmd.wq_pop_hold || cmd.wq_lerp) whold_ff <= wq_head;
      if (cmd.cq_pop_hold || cmd.cq_lerp) chold_ff <= cq_head;
      if (cmd.out_load) out_ff <= cq_head;
      if (cmd.load_param) begin
         u_ff <= (u_in > bpe_pkg::ONE_Q16) ? bpe_pkg::ONE_Q16 : u_in;
         v_ff <= (v_in > bpe_pkg::ONE_Q16) ? bpe_pkg::ONE_Q16 : v_in;
      end
   end

   assign status.out_free = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_point = out_ff;

endmodule

/* rtl/bpe_controller.sv */
module bpe_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [bpe_pkg::IDX_W-1:0]     req_col,
   input  logic [bpe_pkg::IDX_W-1:0]     req_row,
   input  logic [bpe_pkg::DIM_W-1:0]     cols,
   input  logic [bpe_pkg::DIM_W-1:0]     rows,
   input  bpe_pkg::dp_status_type        status,
   output bpe_pkg::ctl_cmd_type          cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_LWAIT = 4'd2;
   localparam logic [3:0] S_WHOLD = 4'd3;
   localparam logic [3:0] S_WLERP = 4'd4;
   localparam logic [3:0] S_MOVE  = 4'd5;
   localparam logic [3:0] S_CHOLD = 4'd6;
   localparam logic [3:0] S_CLERP = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   localparam logic [bpe_pkg::DIM_W-1:0] ONE = bpe_pkg::DIM_W'(1);

   logic [3:0]                state_ff, state_in;
   logic [bpe_pkg::DIM_W-1:0] col_ff, col_in, row_ff, row_in, lvl_ff, lvl_in;
   logic [bpe_pkg::DIM_W-1:0] idx_ff, idx_in, ncols_ff, ncols_in, nrows_ff, nrows_in;
   logic                      accept;

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      lvl_in   = lvl_ff;
      idx_in   = idx_ff;
      ncols_in = ncols_ff;
      nrows_in = nrows_ff;
      cmd      = '0;
      cmd.ram_addr = {req_col, req_row};
      req_ready = (state_ff == S_IDLE);
      accept    = req_valid && req_ready;

      unique case (state_ff)
         // Store a point or start an evaluation
         S_IDLE: begin
            if (accept && req_cmd == bpe_pkg::CMD_WRITE) begin
               cmd.ram_we = ({1'b0, req_col} < cols) && ({1'b0, req_row} < rows);
            end else if (accept) begin
               cmd.load_param = 1'b1;
               ncols_in = cols;
               nrows_in = rows;
               col_in   = '0;
               row_in   = '0;
               state_in = S_LOAD;
            end
         end
         // Read one column of points into the work queue
         S_LOAD: begin
            cmd.ram_re   = 1'b1;
            cmd.ram_addr = {col_ff[bpe_pkg::IDX_W-1:0], row_ff[bpe_pkg::IDX_W-1:0]};
            row_in = row_ff + ONE;
            if (row_ff == nrows_ff - ONE) state_in = S_LWAIT;
         end
         S_LWAIT: begin
            lvl_in   = nrows_ff;
            state_in = (nrows_ff == ONE) ? S_MOVE : S_WHOLD;
         end
         S_WHOLD: begin
            cmd.wq_pop_hold = 1'b1;
            idx_in   = ONE;
            state_in = S_WLERP;
         end
         // One level of the row reduction, one interpolation a cycle
         S_WLERP: begin
            cmd.wq_lerp = 1'b1;
            idx_in = idx_ff + ONE;
            if (idx_ff == lvl_ff - ONE) begin
               lvl_in   = lvl_ff - ONE;
               state_in = (lvl_ff - ONE == ONE) ? S_MOVE : S_WHOLD;
            end
         end
         // Hand the column value to the column queue
         S_MOVE: begin
            cmd.move = 1'b1;
            if (col_ff == ncols_ff - ONE) begin
               lvl_in   = ncols_ff;
               state_in = (ncols_ff == ONE) ? S_OUT : S_CHOLD;
            end else begin
               col_in   = col_ff + ONE;
               row_in   = '0;
               state_in = S_LOAD;
            end
         end
         S_CHOLD: begin
            cmd.cq_pop_hold = 1'b1;
            idx_in   = ONE;
            state_in = S_CLERP;
         end
         S_CLERP: begin
            cmd.cq_lerp = 1'b1;
            idx_in = idx_ff + ONE;
            if (idx_ff == lvl_ff - ONE) begin
               lvl_in   = lvl_ff - ONE;
               state_in = (lvl_ff - ONE == ONE) ? S_OUT : S_CHOLD;
            end
         end
         // Wait for the output register to free up
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      col_ff   <= col_in;
      row_ff   <= row_in;
      lvl_ff   <= lvl_in;
      idx_ff   <= idx_in;
      ncols_ff <= ncols_in;
      nrows_ff <= nrows_in;
   end

endmodule

/* rtl/bezier_patch_evaluator_unit.sv */
// Tensor-product Bezier surface evaluator. A request with cmd 0 stores one
// Q16.16 control point at (point_col, point_row) in a 256-entry point memory;
// a write outside the configured grid is dropped. A request with cmd 1
// evaluates the surface at (u, v) by de Casteljau, first down each column
// with v, then across the column values with u, all on one shared
// interpolator that does one step per cycle. The input stays closed for
// the whole evaluation. The result waits in an output register and the
// next request is taken while it waits. Points must be written before
// they are used; the memory is not cleared.
module bezier_patch_evaluator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd, point_col, point_row, coord_x, coord_y, coord_z, u_param, v_param
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, pos_z
   output logic [95:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [bpe_pkg::DIM_W-1:0] cols_ff, rows_ff;
   bpe_pkg::ctl_cmd_type      cmd;
   bpe_pkg::dp_status_type    status;
   logic                      csr_wr;

   // Register writes
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= bpe_pkg::DIM_W'(4);
         rows_ff <= bpe_pkg::DIM_W'(4);
      end else if (csr_wr) begin
         if (csr_paddr[2] == bpe_pkg::REG_COLUMNS) cols_ff <= csr_pwdata[bpe_pkg::DIM_W-1:0];
         else rows_ff <= csr_pwdata[bpe_pkg::DIM_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == bpe_pkg::REG_ROWS) ?
                       {{(32-bpe_pkg::DIM_W){1'b0}}, rows_ff} :
                       {{(32-bpe_pkg::DIM_W){1'b0}}, cols_ff};

   bpe_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tdata[0]),
      .req_col   (req_tdata[4:1]),
      .req_row   (req_tdata[8:5]),
      .cols      (bpe_pkg::clamp_dim(cols_ff)),
      .rows      (bpe_pkg::clamp_dim(rows_ff)),
      .status    (status),
      .cmd       (cmd)
   );

   bpe_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .wr_point  (req_tdata[104:9]),
      .u_in      (req_tdata[121:105]),
      .v_in      (req_tdata[138:122]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_point (rsp_tdata)
   );

endmodule

/* rtl/bpe_checker.sv */
`include "bezier_patch_evaluator_unit_macros.svh"

module bpe_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [143:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata,
   input logic         csr_pready
);

   // A waiting result holds still
   `BPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // A stored point never yields a result
   `BPE_ASSERT_NEXT(a_write_silent, clock, reset, req_tvalid && req_tready && req_tdata[0] == bpe_pkg::CMD_WRITE && !rsp_tvalid, !rsp_tvalid)
   // An evaluation keeps the input closed for the next cycle
   `BPE_ASSERT_NEXT(a_eval_busy, clock, reset, req_tvalid && req_tready && req_tdata[0] == bpe_pkg::CMD_EVAL, !req_tready)
   // The register port never stalls
   `BPE_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_pready)

endmodule

bind bezier_patch_evaluator_unit bpe_checker u_bpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
